FILE: rtl/downlink_response_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the downlink response scheduler
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef DOWNLINK_RESPONSE_SCHEDULER_UNIT_ASSERT_SVH
`define DOWNLINK_RESPONSE_SCHEDULER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DRS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drs assertion failed");
// next-cycle implication
`define DRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drs assertion failed");
`else
`define DRS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define DRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, codes and helpers of the downlink response scheduler.
// ----------------------------------------------------------------------------
package drs_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_FLIGHT_MINIMAL  = 8'd0;
  localparam logic [7:0] CFG_COMMAND_DELAY   = 8'd1;
  localparam logic [7:0] CFG_DUPLICATE_DELAY = 8'd2;
  localparam logic [7:0] CFG_FAST_PER_DETAIL = 8'd3;
  localparam logic [7:0] CFG_PAGE_COUNT      = 8'd4;

  // configuration reset values
  localparam logic        RST_FLIGHT_MINIMAL  = 1'b1;
  localparam logic [15:0] RST_COMMAND_DELAY   = 16'd4500;
  localparam logic [15:0] RST_DUPLICATE_DELAY = 16'd5000;
  localparam logic [7:0]  RST_FAST_PER_DETAIL = 8'd4;
  localparam logic [5:0]  RST_PAGE_COUNT      = 6'd19;

  localparam logic [5:0] MAX_PAGES = 6'd32;

  // radio send result codes
  localparam logic [1:0] RES_NONE    = 2'd0;
  localparam logic [1:0] RES_SUCCESS = 2'd1;

  // packet kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FAST   = 2'd1;
  localparam logic [1:0] KIND_DETAIL = 2'd2;
  localparam logic [1:0] KIND_DUP    = 2'd3;

  // record of the last primary packet, replayed by a duplicate
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] page;
    logic [7:0] tlm_seq;
    logic [7:0] cmd_seq;
  } saved_pkt_t;

  // counter events of one tick
  typedef struct packed {
    logic        upd_dt;
    logic [31:0] dt;
    logic        inc_succ;
    logic        inc_fail;
    logic        inc_repl;
    logic        inc_canc;
    logic        inc_dups;
  } stat_event_t;

  typedef struct packed {
    logic [31:0] last_dur;
    logic [31:0] max_dur;
    logic [31:0] succ;
    logic [31:0] fail;
    logic [31:0] repl;
    logic [31:0] canc;
    logic [31:0] dups;
  } stat_counters_t;

  // due when the wrapped difference is not negative
  function automatic logic is_due(input logic [31:0] now, input logic [31:0] due);
    logic [31:0] diff;
    diff = now - due;
    return ~diff[31];
  endfunction

  // page count clamped to 1..32
  function automatic logic [5:0] eff_pages(input logic [5:0] cnt);
    logic [5:0] r;
    r = cnt;
    if (cnt == 6'd0) r = 6'd1;
    else if (cnt > MAX_PAGES) r = MAX_PAGES;
    return r;
  endfunction

endpackage

FILE: rtl/drs_tick_if.sv
// ----------------------------------------------------------------------------
// drs_tick_if
// Service tick channel: one transfer per scheduler tick.
// ----------------------------------------------------------------------------
interface drs_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_us;
  logic [1:0]  send_result;
  logic        radio_busy;
  logic        radio_accepts;
  logic [31:0] valid_command_count;
  logic [7:0]  latest_cmd_seq;
  logic        flight_active;

  modport source (
    output valid, now_us, send_result, radio_busy, radio_accepts,
           valid_command_count, latest_cmd_seq, flight_active,
    input  ready
  );
  modport sink (
    input  valid, now_us, send_result, radio_busy, radio_accepts,
           valid_command_count, latest_cmd_seq, flight_active,
    output ready
  );
endinterface

FILE: rtl/drs_result_if.sv
// ----------------------------------------------------------------------------
// drs_result_if
// Result channel: one transfer per service tick.
// ----------------------------------------------------------------------------
interface drs_result_if;
  logic        valid;
  logic        ready;
  logic        start_send;
  logic [1:0]  packet_kind;
  logic [4:0]  page_number;
  logic [7:0]  telemetry_sequence;
  logic [7:0]  echoed_command_seq;
  logic [31:0] last_duration_us;
  logic [31:0] max_duration_us;
  logic [31:0] success_count;
  logic [31:0] fail_count;
  logic [31:0] replace_count;
  logic [31:0] cancel_count;
  logic [31:0] dup_schedule_count;

  modport source (
    output valid, start_send, packet_kind, page_number, telemetry_sequence,
           echoed_command_seq, last_duration_us, max_duration_us, success_count,
           fail_count, replace_count, cancel_count, dup_schedule_count,
    input  ready
  );
  modport sink (
    input  valid, start_send, packet_kind, page_number, telemetry_sequence,
           echoed_command_seq, last_duration_us, max_duration_us, success_count,
           fail_count, replace_count, cancel_count, dup_schedule_count,
    output ready
  );
endinterface

FILE: rtl/drs_cfg_if.sv
// ----------------------------------------------------------------------------
// drs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface drs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/drs_stats.sv
// ----------------------------------------------------------------------------
// drs_stats
// Send timing and wrapping event counters, updated once per accepted tick.
// ----------------------------------------------------------------------------
module drs_stats (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    upd,
  input  drs_pkg::stat_event_t    ev,
  output drs_pkg::stat_counters_t st
);

  drs_pkg::stat_counters_t st_next;

  // next counter values for this tick
  always_comb begin
    st_next = st;
    if (ev.upd_dt) begin
      st_next.last_dur = ev.dt;
      if (ev.dt > st.max_dur) st_next.max_dur = ev.dt;
    end
    if (ev.inc_succ) st_next.succ = st.succ + 32'd1;
    if (ev.inc_fail) st_next.fail = st.fail + 32'd1;
    if (ev.inc_repl) st_next.repl = st.repl + 32'd1;
    if (ev.inc_canc) st_next.canc = st.canc + 32'd1;
    if (ev.inc_dups) st_next.dups = st.dups + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (upd) begin
      st <= st_next;
    end
  end

endmodule

FILE: rtl/downlink_response_scheduler_unit.sv
// ----------------------------------------------------------------------------
// downlink_response_scheduler_unit
// Schedules command responses, detail page rotation and duplicate resends.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the tick transfer; the result
//   register holds the result until it is taken.
// Throughput: one tick per cycle while results are taken; the tick decision is
//   one pass of compares and 32-bit adds into the state and result registers.
// Reset: synchronous, clears all scheduler state and counters and restores
//   the configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "downlink_response_scheduler_unit_assert.svh"

module downlink_response_scheduler_unit (
  input logic         clk,
  input logic         rst,
  drs_tick_if.sink    tick,
  drs_result_if.source result,
  drs_cfg_if.sink     cfg
);

  // configuration
  logic        flight_minimal_mode;
  logic [15:0] command_delay_us;
  logic [15:0] duplicate_delay_us;
  logic [7:0]  fast_per_detail;
  logic [5:0]  page_count;

  // scheduler state
  logic [4:0]  page_cursor, page_cursor_next;
  logic [7:0]  fast_run, fast_run_next;
  logic        fast_in_flight, fast_in_flight_next;
  logic [4:0]  page_in_flight, page_in_flight_next;
  logic        response_pending, response_pending_next;
  logic [7:0]  pending_cmd_seq, pending_cmd_seq_next;
  logic [31:0] response_due, response_due_next;
  logic [31:0] last_seen_count, last_seen_count_next;
  logic        count_primed;
  logic [31:0] send_started_at, send_started_at_next;
  logic        dup_pending, dup_pending_next;
  logic        dup_in_flight, dup_in_flight_next;
  logic [31:0] dup_due, dup_due_next;
  logic [7:0]  tlm_seq, tlm_seq_next;
  drs_pkg::saved_pkt_t saved, saved_next;

  // result register
  logic        rsp_valid;
  logic        rsp_start_send;
  logic [1:0]  rsp_kind;
  logic [4:0]  rsp_page;
  logic [7:0]  rsp_tlm_seq;
  logic [7:0]  rsp_cmd_seq;

  // per-tick decision
  logic        tick_fire;
  logic        minimal;
  logic        newcmd;
  logic        prim_send;
  logic [31:0] lsc;
  logic [5:0]  page_inc;
  logic [1:0]  snd_kind;
  logic [4:0]  snd_page;
  logic [7:0]  snd_tlm;
  logic [7:0]  snd_cmd;
  logic [1:0]  cand_kind;
  logic [4:0]  cand_page;

  drs_pkg::stat_event_t    ev;
  drs_pkg::stat_counters_t st;

  assign tick.ready = ~rsp_valid | result.ready;
  assign tick_fire  = tick.valid & tick.ready;
  assign cfg.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flight_minimal_mode <= drs_pkg::RST_FLIGHT_MINIMAL;
      command_delay_us    <= drs_pkg::RST_COMMAND_DELAY;
      duplicate_delay_us  <= drs_pkg::RST_DUPLICATE_DELAY;
      fast_per_detail     <= drs_pkg::RST_FAST_PER_DETAIL;
      page_count          <= drs_pkg::RST_PAGE_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        drs_pkg::CFG_FLIGHT_MINIMAL:  flight_minimal_mode <= cfg.data[0];
        drs_pkg::CFG_COMMAND_DELAY:   command_delay_us    <= cfg.data;
        drs_pkg::CFG_DUPLICATE_DELAY: duplicate_delay_us  <= cfg.data;
        drs_pkg::CFG_FAST_PER_DETAIL: fast_per_detail     <= cfg.data[7:0];
        drs_pkg::CFG_PAGE_COUNT:      page_count          <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // tick decision, in the order the events take effect
  always_comb begin
    page_cursor_next       = page_cursor;
    fast_run_next          = fast_run;
    fast_in_flight_next    = fast_in_flight;
    page_in_flight_next    = page_in_flight;
    response_pending_next  = response_pending;
    pending_cmd_seq_next   = pending_cmd_seq;
    response_due_next      = response_due;
    send_started_at_next   = send_started_at;
    dup_pending_next       = dup_pending;
    dup_in_flight_next     = dup_in_flight;
    dup_due_next           = dup_due;
    tlm_seq_next           = tlm_seq;
    saved_next             = saved;
    snd_kind               = drs_pkg::KIND_NONE;
    snd_page               = 5'd0;
    snd_tlm                = 8'd0;
    snd_cmd                = 8'd0;
    cand_kind              = drs_pkg::KIND_FAST;
    cand_page              = 5'd0;
    prim_send              = 1'b0;
    page_inc               = {1'b0, page_in_flight} + 6'd1;
    ev                     = '0;
    ev.dt                  = tick.now_us - send_started_at;

    minimal = tick.flight_active & flight_minimal_mode;
    // first tick loads the count without seeing a command
    lsc = count_primed ? last_seen_count : tick.valid_command_count;
    last_seen_count_next = lsc;

    // send completion
    if (tick.send_result != drs_pkg::RES_NONE) begin
      ev.upd_dt = 1'b1;
      if (dup_in_flight) begin
        dup_in_flight_next = 1'b0;
      end else if (tick.send_result == drs_pkg::RES_SUCCESS) begin
        ev.inc_succ = 1'b1;
        if (minimal) begin
          dup_pending_next   = 1'b0;
          dup_in_flight_next = 1'b0;
        end else begin
          dup_pending_next = 1'b1;
          dup_due_next     = tick.now_us + {16'd0, duplicate_delay_us};
          ev.inc_dups      = 1'b1;
          if (fast_in_flight) begin
            if (fast_run < fast_per_detail)
              fast_run_next = fast_run + 8'd1;
          end else begin
            page_cursor_next = (page_inc >= drs_pkg::eff_pages(page_count)) ?
                               5'd0 : page_inc[4:0];
            fast_run_next = 8'd0;
          end
        end
      end else begin
        ev.inc_fail = 1'b1;
      end
    end

    newcmd = (tick.valid_command_count != lsc);

    // cancel a waiting duplicate in minimal mode or on a new command
    if ((minimal || newcmd) && dup_pending_next && !dup_in_flight_next) begin
      dup_pending_next = 1'b0;
      ev.inc_canc      = 1'b1;
    end

    // new command schedules a response
    if (newcmd) begin
      last_seen_count_next  = tick.valid_command_count;
      ev.inc_repl           = response_pending;
      response_pending_next = 1'b1;
      pending_cmd_seq_next  = tick.latest_cmd_seq;
      response_due_next     = tick.now_us + {16'd0, command_delay_us};
    end

    // start a primary response, else a due duplicate
    if (response_pending_next && !tick.radio_busy &&
        drs_pkg::is_due(tick.now_us, response_due_next)) begin
      if (minimal || fast_run_next < fast_per_detail) begin
        fast_in_flight_next = 1'b1;
      end else begin
        cand_kind           = drs_pkg::KIND_DETAIL;
        cand_page           = page_cursor_next;
        page_in_flight_next = page_cursor_next;
        fast_in_flight_next = 1'b0;
      end
      if (tick.radio_accepts) begin
        if (!minimal) begin
          saved_next.kind    = cand_kind;
          saved_next.page    = cand_page;
          saved_next.tlm_seq = tlm_seq;
          saved_next.cmd_seq = pending_cmd_seq_next;
        end
        response_pending_next = 1'b0;
        send_started_at_next  = tick.now_us;
        snd_kind              = cand_kind;
        snd_page              = cand_page;
        snd_tlm               = tlm_seq;
        snd_cmd               = pending_cmd_seq_next;
        tlm_seq_next          = tlm_seq + 8'd1;
        prim_send             = 1'b1;
      end
    end else if (!minimal && dup_pending_next && !tick.radio_busy &&
                 drs_pkg::is_due(tick.now_us, dup_due_next)) begin
      if (tick.radio_accepts) begin
        dup_pending_next     = 1'b0;
        dup_in_flight_next   = 1'b1;
        send_started_at_next = tick.now_us;
        snd_kind             = drs_pkg::KIND_DUP;
        snd_page             = saved.page;
        snd_tlm              = saved.tlm_seq;
        snd_cmd              = saved.cmd_seq;
      end
    end
  end

  // state update on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      page_cursor       <= '0;
      fast_run          <= '0;
      fast_in_flight    <= 1'b0;
      page_in_flight    <= '0;
      response_pending  <= 1'b0;
      pending_cmd_seq   <= '0;
      response_due      <= '0;
      last_seen_count   <= '0;
      count_primed      <= 1'b0;
      send_started_at   <= '0;
      dup_pending       <= 1'b0;
      dup_in_flight     <= 1'b0;
      dup_due           <= '0;
      tlm_seq           <= '0;
      saved             <= '0;
    end else if (tick_fire) begin
      page_cursor       <= page_cursor_next;
      fast_run          <= fast_run_next;
      fast_in_flight    <= fast_in_flight_next;
      page_in_flight    <= page_in_flight_next;
      response_pending  <= response_pending_next;
      pending_cmd_seq   <= pending_cmd_seq_next;
      response_due      <= response_due_next;
      last_seen_count   <= last_seen_count_next;
      count_primed      <= 1'b1;
      send_started_at   <= send_started_at_next;
      dup_pending       <= dup_pending_next;
      dup_in_flight     <= dup_in_flight_next;
      dup_due           <= dup_due_next;
      tlm_seq           <= tlm_seq_next;
      saved             <= saved_next;
    end
  end

  // counters; they change only with a tick transfer, so they match the result
  drs_stats u_stats (
    .clk (clk),
    .rst (rst),
    .upd (tick_fire),
    .ev  (ev),
    .st  (st)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (tick_fire) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      rsp_start_send <= (snd_kind != drs_pkg::KIND_NONE);
      rsp_kind       <= snd_kind;
      rsp_page       <= snd_page;
      rsp_tlm_seq    <= snd_tlm;
      rsp_cmd_seq    <= snd_cmd;
    end
  end

  assign result.valid              = rsp_valid;
  assign result.start_send         = rsp_start_send;
  assign result.packet_kind        = rsp_kind;
  assign result.page_number        = rsp_page;
  assign result.telemetry_sequence = rsp_tlm_seq;
  assign result.echoed_command_seq = rsp_cmd_seq;
  assign result.last_duration_us   = st.last_dur;
  assign result.max_duration_us    = st.max_dur;
  assign result.success_count      = st.succ;
  assign result.fail_count         = st.fail;
  assign result.replace_count      = st.repl;
  assign result.cancel_count       = st.canc;
  assign result.dup_schedule_count = st.dups;

  // checks
  `DRS_ASSERT_NEXT(a_tick_gives_result, clk, rst, tick_fire, result.valid)
  `DRS_ASSERT_NEXT(a_stall_holds_state, clk, rst, result.valid && !result.ready,
                   $stable(tlm_seq) && $stable(dup_pending))
  `DRS_ASSERT_NEXT(a_primary_bumps_seq, clk, rst, tick_fire && prim_send,
                   tlm_seq == $past(tlm_seq) + 8'd1)
  `DRS_ASSERT_IMPL(a_max_covers_last, clk, rst, 1'b1, st.max_dur >= st.last_dur)

endmodule
